FILE: rtl/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg
// Types, codes and constants shared by the rotator position controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

  localparam int POT_BITS  = 10;
  localparam int CFG_BITS  = 8;
  localparam int SEC_BITS  = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CMP_BITS  = POT_BITS + 1;

  localparam logic [CFG_BITS-1:0] DEADBAND_RST     = CFG_BITS'(5);
  localparam logic [CFG_BITS-1:0] STALL_WINDOW_RST = CFG_BITS'(3);
  localparam logic [CFG_BITS-1:0] PERIOD_RST       = CFG_BITS'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADBAND      = 2'd0,
    REG_STALL_WINDOW  = 2'd1,
    REG_PERIOD        = 2'd2,
    REG_DRIVE_PRESENT = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_START    = 2'd1,
    CMD_CONTROL  = 2'd2,
    CMD_PROGRESS = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_START = 3'd1,
    MODE_CCW   = 3'd2,
    MODE_CW    = 3'd3,
    MODE_ERROR = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_CCW  = 2'd1,
    ACT_CW   = 2'd2,
    ACT_STOP = 2'd3
  } act_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [POT_BITS-1:0] control_pot;
    logic [POT_BITS-1:0] rotator_pot;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] drive;
    logic       busy_res;
    logic       progress_ok;
  } out_item_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] deadband;
    logic [CFG_BITS-1:0] stall_window;
    logic [CFG_BITS-1:0] progress_period;
    logic                drive_present;
  } cfg_t;

  typedef struct packed {
    mode_t               mode;
    logic [SEC_BITS-1:0] seconds_now;
    logic [SEC_BITS-1:0] deadline;
    logic [POT_BITS-1:0] position;
  } ctl_state_t;

endpackage

`default_nettype wire

FILE: rtl/rpc_cfg.sv
// ----------------------------------------------------------------------------
// rpc_cfg
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rpc_pkg::CFG_BITS-1:0]  cfg_wdata,
  output rpc_pkg::cfg_t                     cfg
);
  import rpc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DEADBAND:      cfg_nxt.deadband        = cfg_wdata;
        REG_STALL_WINDOW:  cfg_nxt.stall_window    = cfg_wdata;
        REG_PERIOD:        cfg_nxt.progress_period = cfg_wdata;
        REG_DRIVE_PRESENT: cfg_nxt.drive_present   = cfg_wdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband        <= DEADBAND_RST;
      cfg_r.stall_window    <= STALL_WINDOW_RST;
      cfg_r.progress_period <= PERIOD_RST;
      cfg_r.drive_present   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: rtl/rpc_step.sv
// ----------------------------------------------------------------------------
// rpc_step
// Next-state and result logic for one command.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_step (
  input  wire rpc_pkg::cfg_t       cfg,
  input  wire rpc_pkg::ctl_state_t cur,
  input  wire rpc_pkg::in_item_t   item,
  output rpc_pkg::ctl_state_t      nxt,
  output rpc_pkg::out_item_t       res
);
  import rpc_pkg::*;

  logic [POT_BITS-1:0] ctrl;
  logic [POT_BITS-1:0] rot;
  logic [CMP_BITS-1:0] ctrl_w;
  logic [CMP_BITS-1:0] rot_w;
  logic [CMP_BITS-1:0] pos_w;
  logic [CMP_BITS-1:0] db_w;
  logic [CMP_BITS-1:0] sw_w;
  logic [SEC_BITS-1:0] new_deadline;
  act_t                act;
  logic                ok;

  assign ctrl   = cfg.drive_present ? item.control_pot : '0;
  assign rot    = cfg.drive_present ? item.rotator_pot : '0;
  assign ctrl_w = CMP_BITS'(ctrl);
  assign rot_w  = CMP_BITS'(rot);
  assign pos_w  = CMP_BITS'(cur.position);
  assign db_w   = CMP_BITS'(cfg.deadband);
  assign sw_w   = CMP_BITS'(cfg.stall_window);
  assign new_deadline = cur.seconds_now + SEC_BITS'(cfg.progress_period);

  always_comb begin
    nxt = cur;
    act = ACT_NONE;
    ok  = 1'b1;
    case (cmd_t'(item.cmd))
      CMD_TICK: begin
        nxt.seconds_now = cur.seconds_now + SEC_BITS'(1);
      end
      CMD_START: begin
        if (cur.mode == MODE_IDLE || cur.mode == MODE_ERROR) begin
          nxt.mode     = MODE_START;
          nxt.deadline = new_deadline;
          nxt.position = rot;
        end else begin
          nxt.deadline = '0;
          nxt.position = '0;
        end
      end
      CMD_CONTROL: begin
        case (cur.mode)
          MODE_START: begin
            if (ctrl_w > rot_w + db_w) begin
              nxt.mode = cfg.drive_present ? MODE_CCW : MODE_ERROR;
              act      = cfg.drive_present ? ACT_CCW : ACT_NONE;
            end else if (ctrl_w + db_w < rot_w) begin
              nxt.mode = cfg.drive_present ? MODE_CW : MODE_ERROR;
              act      = cfg.drive_present ? ACT_CW : ACT_NONE;
            end else begin
              nxt.mode = MODE_IDLE;
            end
          end
          MODE_CCW: begin
            if (ctrl <= rot) begin
              nxt.mode = cfg.drive_present ? MODE_IDLE : MODE_ERROR;
              act      = cfg.drive_present ? ACT_STOP : ACT_NONE;
            end
          end
          MODE_CW: begin
            if (ctrl >= rot) begin
              nxt.mode = cfg.drive_present ? MODE_IDLE : MODE_ERROR;
              act      = cfg.drive_present ? ACT_STOP : ACT_NONE;
            end
          end
          default: begin
            nxt.mode = cur.mode;
          end
        endcase
      end
      CMD_PROGRESS: begin
        if ((cur.mode == MODE_CCW || cur.mode == MODE_CW) &&
            (cur.deadline < cur.seconds_now)) begin
          if ((rot_w + sw_w > pos_w) && (rot_w < pos_w + sw_w)) begin
            ok       = 1'b0;
            act      = cfg.drive_present ? ACT_STOP : ACT_NONE;
            nxt.mode = MODE_ERROR;
          end else begin
            nxt.deadline = new_deadline;
            nxt.position = rot;
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  assign res.status      = nxt.mode;
  assign res.drive       = act;
  assign res.busy_res    = (nxt.mode != MODE_IDLE);
  assign res.progress_ok = ok;

endmodule

`default_nettype wire

FILE: rtl/rotator_position_controller_unit.sv
// ----------------------------------------------------------------------------
// rotator_position_controller_unit
// Rotator position controller: deadband drive decisions and stall detection.
// ----------------------------------------------------------------------------
// Path: an input transfer is held in the input register, then its result is
//   loaded into the result register; the controller state updates as the result loads.
// Throughput: one command per cycle while the result side does not stall.
// Reset: synchronous, active low; clears both stages, the controller state
//   (mode idle, counters zero) and loads the register defaults.
`default_nettype none

module rotator_position_controller_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire rpc_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output rpc_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rpc_pkg::CFG_BITS-1:0]  cfg_wdata
);
  import rpc_pkg::*;

  cfg_t       cfg;
  in_item_t   item_r;
  logic       item_vld_r;
  out_item_t  res_r;
  logic       res_vld_r;
  ctl_state_t st_r;
  ctl_state_t st_nxt;
  out_item_t  res_nxt;
  logic       res_free;
  logic       advance;

  rpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rpc_step u_step (
    .cfg  (cfg),
    .cur  (st_r),
    .item (item_r),
    .nxt  (st_nxt),
    .res  (res_nxt)
  );

  assign res_free = !res_vld_r || !out_stall;
  assign advance  = item_vld_r && res_free;
  assign in_stall = item_vld_r && !res_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (!in_stall) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (res_free) begin
      res_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode        <= MODE_IDLE;
      st_r.seconds_now <= '0;
      st_r.deadline    <= '0;
      st_r.position    <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

`ifndef SYNTH
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (item_vld_r && res_vld_r && out_stall))
    else $error("input stalled while pipeline not full");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.busy_res == (out_data.status != MODE_IDLE)))
    else $error("busy flag disagrees with status");

  a_stall_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.progress_ok) |-> (out_data.status == MODE_ERROR))
    else $error("stall reported without error status");

  a_ccw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.drive == ACT_CCW) |-> (out_data.status == MODE_CCW))
    else $error("ccw drive without ccw status");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(st_r))
    else $error("controller state changed without a transfer");
`endif

endmodule

`default_nettype wire
